[hdl/vmip_pkg.sv]
`default_nettype none

package vmip_pkg;

  // decoded membership of one plane entry, current and previous x plane
  typedef struct packed {
    logic cur;
    logic prev;
  } nbr_bits_t;

  // configuration register indexes
  localparam logic REG_VOLUME_DIM = 1'b0;
  localparam logic REG_BIT_MASK   = 1'b1;

  localparam int unsigned DIM_W   = 5;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 4;

  localparam logic [DIM_W-1:0]  DIM_RESET  = 5'd16;
  localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_NONE  = 8'h00;

endpackage

`default_nettype wire

[hdl/vmip_plane_mem.sv]
`default_nettype none

module vmip_plane_mem
  import vmip_pkg::*;
#(
  parameter  int unsigned MAX_EDGE = 16,
  localparam int unsigned DEPTH    = MAX_EDGE * MAX_EDGE,
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW       = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_row_addr_i,
  input  wire logic [AW-1:0] rd_up_addr_i,
  input  wire logic [CW-1:0] plane_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic          wr_val_i,
  input  wire logic          wr_old_i,
  input  wire logic [CW-1:0] wr_tag_i,
  input  wire logic          clr_i,
  output nbr_bits_t          row_o,
  output nbr_bits_t          up_o
);

  localparam int unsigned WW = CW + 2;

  // entry layout: {plane tag, value before that plane's write, latest value}
  logic [WW-1:0]    mem_q [DEPTH];
  logic [WW-1:0]    row_word_q, up_word_q, fwd_word_q;
  logic [WW-1:0]    wr_word, row_word, up_word;
  logic [AW-1:0]    row_addr_q, up_addr_q;
  logic             fwd_row_q, fwd_up_q;
  logic [DEPTH-1:0] valid_q;
  logic             row_vld, up_vld;

  assign wr_word = {wr_tag_i, wr_old_i, wr_val_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_word;
    end
    if (rd_en_i) begin
      row_word_q <= mem_q[rd_row_addr_i];
      up_word_q  <= mem_q[rd_up_addr_i];
      row_addr_q <= rd_row_addr_i;
      up_addr_q  <= rd_up_addr_i;
      fwd_word_q <= wr_word;
    end
  end

  // a write landing at the read edge is not seen by the array read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_row_q <= 1'b0;
      fwd_up_q  <= 1'b0;
    end else if (rd_en_i) begin
      fwd_row_q <= wr_en_i && (wr_addr_i == rd_row_addr_i);
      fwd_up_q  <= wr_en_i && (wr_addr_i == rd_up_addr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign row_word = fwd_row_q ? fwd_word_q : row_word_q;
  assign up_word  = fwd_up_q ? fwd_word_q : up_word_q;
  assign row_vld  = valid_q[row_addr_q];
  assign up_vld   = valid_q[up_addr_q];

  // written in this plane: previous plane saw the old value
  assign row_o.cur  = row_vld & row_word[0];
  assign row_o.prev = row_vld & ((row_word[WW-1:2] == plane_i) ? row_word[1] : row_word[0]);
  assign up_o.cur   = up_vld & up_word[0];
  assign up_o.prev  = up_vld & ((up_word[WW-1:2] == plane_i) ? up_word[1] : up_word[0]);

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (valid_q == '0))
    else $error("plane store not cleared at end of volume");

  a_wr_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !clr_i) |=> valid_q[$past(wr_addr_i)])
    else $error("written plane entry not marked valid");

endmodule

`default_nettype wire

[hdl/voxel_map_to_inversion_points_core.sv]
`default_nettype none

// Streaming inversion-point finder for a cubic voxel volume.
// Input channel (in_valid_i/in_ready_o, voxel_byte_i) takes one voxel byte per
// word in raster order: x outer, y middle, z inner. Every accepted word gives
// exactly one output word (out_valid_o/out_ready_i) carrying point_flag_o,
// the voxel coordinates and volume_end_o on the last voxel of the volume.
// An accepted voxel is held in the combine stage register, then the output
// register; throughput is one voxel per cycle while out_ready_i is high. Each
// voxel reads two entries of the plane store (same and lower y) through its two
// read ports; the lower-z neighbours come from the previous voxel's registers,
// and a write of the previous voxel to an entry being read is forwarded.
// The output register decouples the sides: a new word is accepted while a
// finished word waits, and a stalled receiver backs up the pipeline by one
// stage before in_ready_o drops.
// Reset clears the counters, the plane store valid bits and the pipeline, and
// sets volume_dim to 16 and bit_mask to 0xFF. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
module voxel_map_to_inversion_points_core
  import vmip_pkg::*;
#(
  parameter int unsigned MAX_EDGE = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [MASK_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] voxel_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   point_flag_o,
  output logic [COORD_W-1:0]     point_x_o,
  output logic [COORD_W-1:0]     point_y_o,
  output logic [COORD_W-1:0]     point_z_o,
  output logic                   volume_end_o
);

  localparam int unsigned DEPTH = MAX_EDGE * MAX_EDGE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int unsigned EW    = $clog2(MAX_EDGE + 1);

  logic [DIM_W-1:0]  dim_q;
  logic [MASK_W-1:0] mask_q;
  logic [EW-1:0]     edge_len;

  logic [CW-1:0] cnt_x_q, cnt_y_q, cnt_z_q;
  logic          end_row, end_plane, end_vol;
  logic          in_fire, member;
  logic [AW-1:0] rd_row_addr, rd_up_addr;

  logic          s1_valid_q, s1_member_q, s1_end_q;
  logic [CW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic          s1_fire, s1_flag;
  logic          x_nz, y_nz, z_nz;
  logic [AW-1:0] s1_addr;
  logic [CW+COORD_W-1:0] x_ext, y_ext, z_ext;

  nbr_bits_t row_nb, up_nb, left_row_q, left_up_q;

  logic               out_valid_q, out_flag_q, out_end_q;
  logic [COORD_W-1:0] out_x_q, out_y_q, out_z_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_RESET;
      mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VOLUME_DIM: dim_q  <= cfg_data_i[DIM_W-1:0];
        REG_BIT_MASK:   mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_q == '0) begin
      edge_len = EW'(1);
    end else if (32'(dim_q) > MAX_EDGE) begin
      edge_len = EW'(MAX_EDGE);
    end else begin
      edge_len = EW'(dim_q);
    end
  end

  // accept stage: coordinate counters and plane store reads
  assign in_fire   = in_valid_i && in_ready_o;
  assign member    = (voxel_byte_i & mask_q) != MASK_NONE;
  assign end_row   = (EW'(cnt_z_q) + EW'(1)) >= edge_len;
  assign end_plane = end_row && ((EW'(cnt_y_q) + EW'(1)) >= edge_len);
  assign end_vol   = end_plane && ((EW'(cnt_x_q) + EW'(1)) >= edge_len);

  assign rd_row_addr = AW'(cnt_y_q) * AW'(MAX_EDGE) + AW'(cnt_z_q);
  assign rd_up_addr  = AW'(cnt_y_q - CW'(1)) * AW'(MAX_EDGE) + AW'(cnt_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_x_q <= '0;
      cnt_y_q <= '0;
      cnt_z_q <= '0;
    end else if (in_fire) begin
      if (!end_row) begin
        cnt_z_q <= cnt_z_q + CW'(1);
      end else if (!end_plane) begin
        cnt_z_q <= '0;
        cnt_y_q <= cnt_y_q + CW'(1);
      end else if (!end_vol) begin
        cnt_z_q <= '0;
        cnt_y_q <= '0;
        cnt_x_q <= cnt_x_q + CW'(1);
      end else begin
        cnt_z_q <= '0;
        cnt_y_q <= '0;
        cnt_x_q <= '0;
      end
    end
  end

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q      <= cnt_x_q;
      s1_y_q      <= cnt_y_q;
      s1_z_q      <= cnt_z_q;
      s1_member_q <= member;
      s1_end_q    <= end_vol;
    end
  end

  vmip_plane_mem #(
    .MAX_EDGE (MAX_EDGE)
  ) u_plane_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (in_fire),
    .rd_row_addr_i (rd_row_addr),
    .rd_up_addr_i  (rd_up_addr),
    .plane_i       (s1_x_q),
    .wr_en_i       (s1_fire),
    .wr_addr_i     (s1_addr),
    .wr_val_i      (s1_member_q),
    .wr_old_i      (row_nb.cur),
    .wr_tag_i      (s1_x_q),
    .clr_i         (s1_fire && s1_end_q),
    .row_o         (row_nb),
    .up_o          (up_nb)
  );

  // combine stage: xor of the voxel and its seven lower neighbours
  assign s1_addr = AW'(s1_y_q) * AW'(MAX_EDGE) + AW'(s1_z_q);
  assign x_nz    = s1_x_q != '0;
  assign y_nz    = s1_y_q != '0;
  assign z_nz    = s1_z_q != '0;

  assign s1_flag = s1_member_q
                 ^ (y_nz & up_nb.cur)
                 ^ (z_nz & left_row_q.cur)
                 ^ (y_nz & z_nz & left_up_q.cur)
                 ^ (x_nz & (row_nb.prev
                          ^ (y_nz & up_nb.prev)
                          ^ (z_nz & left_row_q.prev)
                          ^ (y_nz & z_nz & left_up_q.prev)));

  // lower-z neighbours of the next voxel in the row
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      left_row_q.cur  <= s1_member_q;
      left_row_q.prev <= row_nb.prev;
      left_up_q       <= up_nb;
    end
  end

  assign x_ext = {{COORD_W{1'b0}}, s1_x_q};
  assign y_ext = {{COORD_W{1'b0}}, s1_y_q};
  assign z_ext = {{COORD_W{1'b0}}, s1_z_q};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_flag_q <= s1_flag;
      out_x_q    <= x_ext[COORD_W-1:0];
      out_y_q    <= y_ext[COORD_W-1:0];
      out_z_q    <= z_ext[COORD_W-1:0];
      out_end_q  <= s1_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_flag_o = out_flag_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign point_z_o    = out_z_q;
  assign volume_end_o = out_end_q;

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_vol) |=> (cnt_x_q == '0 && cnt_y_q == '0 && cnt_z_q == '0))
    else $error("counters did not restart after the last voxel");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q)
                                  && $stable(s1_z_q) && $stable(s1_member_q)))
    else $error("stalled voxel lost its stage contents");

endmodule

`default_nettype wire

[tb/sv/tb_voxel_map_to_inversion_points_core.sv]
`default_nettype none

module tb_voxel_map_to_inversion_points_core;
  import vmip_pkg::*;

  localparam int unsigned MAX_SIDE = 16;

  typedef struct packed {
    logic               flag;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } point_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_idx_i    = REG_VOLUME_DIM;
  logic [MASK_W-1:0] cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] voxel_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic              point_flag_o;
  logic [COORD_W-1:0] point_x_o;
  logic [COORD_W-1:0] point_y_o;
  logic [COORD_W-1:0] point_z_o;
  logic              volume_end_o;

  voxel_map_to_inversion_points_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .voxel_byte_i (voxel_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_flag_o (point_flag_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .volume_end_o (volume_end_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // shadow of the block: configuration, plane stores and raster counters
  logic [DIM_W-1:0]  shadow_dim  = DIM_RESET;
  logic [MASK_W-1:0] shadow_mask = MASK_RESET;
  bit [MAX_SIDE*MAX_SIDE-1:0] plane_now  = '0;
  bit [MAX_SIDE*MAX_SIDE-1:0] plane_last = '0;
  int unsigned pos_x = 0;
  int unsigned pos_y = 0;
  int unsigned pos_z = 0;

  point_t pending_points[$];
  int mismatches    = 0;
  int voxels_sent   = 0;
  int random_voxels = 0;
  int words_seen    = 0;
  int points_seen   = 0;
  int volumes_seen  = 0;
  bit steady_flow   = 1'b0;

  function automatic int unsigned side_len();
    if (shadow_dim == 0) return 1;
    if (shadow_dim > MAX_SIDE) return MAX_SIDE;
    return shadow_dim;
  endfunction

  function automatic point_t predict_point(input logic [BYTE_W-1:0] b);
    point_t p;
    int unsigned span, x, y, z;
    logic member, acc;
    logic row_done, plane_done, vol_done;
    span = side_len();
    x = pos_x;
    y = pos_y;
    z = pos_z;
    member = |(b & shadow_mask);
    acc = member;
    if (y > 0) acc ^= plane_now[(y-1)*MAX_SIDE + z];
    if (z > 0) acc ^= plane_now[y*MAX_SIDE + z - 1];
    if (y > 0 && z > 0) acc ^= plane_now[(y-1)*MAX_SIDE + z - 1];
    if (x > 0) begin
      acc ^= plane_last[y*MAX_SIDE + z];
      if (y > 0) acc ^= plane_last[(y-1)*MAX_SIDE + z];
      if (z > 0) acc ^= plane_last[y*MAX_SIDE + z - 1];
      if (y > 0 && z > 0) acc ^= plane_last[(y-1)*MAX_SIDE + z - 1];
    end
    plane_now[y*MAX_SIDE + z] = member;
    row_done   = (z + 1) >= span;
    plane_done = row_done && (y + 1) >= span;
    vol_done   = plane_done && (x + 1) >= span;
    p.flag = acc;
    p.x    = x[COORD_W-1:0];
    p.y    = y[COORD_W-1:0];
    p.z    = z[COORD_W-1:0];
    p.last = vol_done;
    if (!row_done) begin
      pos_z = z + 1;
    end else if (!plane_done) begin
      pos_z = 0;
      pos_y = y + 1;
    end else if (!vol_done) begin
      pos_z = 0;
      pos_y = 0;
      pos_x = x + 1;
      plane_last = plane_now;
    end else begin
      pos_z = 0;
      pos_y = 0;
      pos_x = 0;
      plane_last = '0;
      plane_now  = '0;
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] random_voxel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    if (r < 6) return BYTE_W'(1 << $urandom_range(0, BYTE_W-1));
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // sends one voxel word; valid stays up until accepted
  task automatic push_voxel(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid_i   <= 1'b1;
    voxel_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(predict_point(b));
    voxels_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [MASK_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_VOLUME_DIM: shadow_dim = data[DIM_W-1:0];
      default:        shadow_mask = data;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a one-voxel edge ends the volume whatever the counters hold
  task automatic restart_volume();
    wait_idle();
    write_reg(REG_VOLUME_DIM, MASK_W'(1));
    push_voxel(random_voxel());
    wait_idle();
  endtask

  task automatic test_byte_extremes();
    push_voxel(8'h00);
    push_voxel(8'hFF);
    push_voxel(8'h01);
    push_voxel(8'h80);
    push_voxel(8'h55);
    push_voxel(8'hAA);
  endtask

  // counters sit past the new edge and must wrap at their next carry
  task automatic test_dim_change_mid_volume();
    wait_idle();
    write_reg(REG_VOLUME_DIM, MASK_W'(2));
    repeat (8) push_voxel(random_voxel());
  endtask

  task automatic test_dim_limits();
    wait_idle();
    write_reg(REG_VOLUME_DIM, MASK_W'(0));
    push_voxel(8'hFF);
    push_voxel(8'h00);
    push_voxel(8'hFF);
    wait_idle();
    write_reg(REG_VOLUME_DIM, 8'hFF);
    push_voxel(8'h10);
    push_voxel(8'hFF);
  endtask

  task automatic test_zero_mask();
    wait_idle();
    write_reg(REG_VOLUME_DIM, MASK_W'(2));
    write_reg(REG_BIT_MASK, MASK_NONE);
    repeat (8) push_voxel(8'hFF);
    wait_idle();
    write_reg(REG_BIT_MASK, MASK_RESET);
  endtask

  task automatic test_full_volume();
    restart_volume();
    write_reg(REG_VOLUME_DIM, MASK_W'(MAX_SIDE / 2));
    write_reg(REG_BIT_MASK, MASK_W'($urandom_range(1, 255)));
    repeat ((MAX_SIDE / 2) * (MAX_SIDE / 2) * (MAX_SIDE / 2)) push_voxel(random_voxel());
  endtask

  task automatic test_random_volumes();
    int r, span, n;
    logic [DIM_W-1:0] dim;
    logic [MASK_W-1:0] mask;
    while (random_voxels < 500) begin
      wait_idle();
      steady_flow = ($urandom_range(0, 4) == 0);
      // mostly clean volumes, the rest continue with counters mid-volume
      if ($urandom_range(0, 4) != 0) restart_volume();
      r = $urandom_range(0, 99);
      if (r < 10)      dim = '0;
      else if (r < 20) dim = DIM_W'($urandom_range(17, 31));
      else if (r < 80) dim = DIM_W'($urandom_range(1, 5));
      else             dim = DIM_W'($urandom_range(6, 16));
      write_reg(REG_VOLUME_DIM, {3'($urandom), dim});
      r = $urandom_range(0, 99);
      if (r < 10)      mask = MASK_NONE;
      else if (r < 25) mask = MASK_RESET;
      else if (r < 50) mask = MASK_W'(1 << $urandom_range(0, MASK_W-1));
      else             mask = MASK_W'($urandom);
      write_reg(REG_BIT_MASK, mask);
      span = (dim == 0) ? 1 : (dim > MAX_SIDE) ? MAX_SIDE : dim;
      n = span * span * span * $urandom_range(1, 3);
      if (n > 300) n = $urandom_range(50, 300);
      repeat (n) push_voxel(random_voxel());
      random_voxels += n;
    end
    steady_flow = 1'b0;
  endtask

  initial begin : sink_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (steady_flow || hold == 0) begin
        out_ready_i <= 1'b1;
        if (!steady_flow) hold = pick_gap();
      end else begin
        out_ready_i <= 1'b0;
        hold--;
      end
    end
  end

  always @(posedge clk_i) begin : watch_out
    point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (point_flag_o) points_seen++;
      if (volume_end_o) volumes_seen++;
      if (pending_points.size() == 0) begin
        $display("%0t: word with nothing expected, flag %0d at (%0d,%0d,%0d) end %0d",
                 $time, point_flag_o, point_x_o, point_y_o, point_z_o, volume_end_o);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_flag", want.flag, point_flag_o);
        check_field("point_x", want.x, point_x_o);
        check_field("point_y", want.y, point_y_o);
        check_field("point_z", want.z, point_z_o);
        check_field("volume_end", want.last, volume_end_o);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout with %0d words outstanding", $time, pending_points.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_byte_extremes();
    test_dim_change_mid_volume();
    test_dim_limits();
    test_zero_mask();
    test_full_volume();
    test_random_volumes();
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("sent %0d voxels, %0d of them in random phases; checked %0d words",
             voxels_sent, random_voxels, words_seen);
    $display("saw %0d inversion points over %0d finished volumes", points_seen, volumes_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/vmip_pkg.sv
hdl/vmip_plane_mem.sv
hdl/voxel_map_to_inversion_points_core.sv
tb/sv/tb_voxel_map_to_inversion_points_core.sv
